[rtl/core/stq_pkg.sv]
// shared types and sizes for the sorted timer expiry queue
package stq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 4;
  localparam int TAG_BITS    = 8;
  localparam int TIME_BITS   = 32;

  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] expiry;
    logic [ID_BITS-1:0]   id;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic                 ins;
    logic                 pop;
    logic [TIME_BITS-1:0] expiry;
    logic [ID_BITS-1:0]   id;
    logic [TAG_BITS-1:0]  tag;
  } cell_ctrl_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_POP
  } state_t;

endpackage

[rtl/core/stq_cell.sv]
// one slot of the sorted chain: keeps an entry, shifts right on insert, left on pop
module stq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  stq_pkg::cell_ctrl_t ctrl,
  input  stq_pkg::entry_t   left_ent,
  input  logic              left_gt,
  input  stq_pkg::entry_t   right_ent,
  output stq_pkg::entry_t   ent,
  output logic              gt
);
  import stq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // entry is later than the new request, so the request goes in front of it
  assign gt  = ent_r.valid && (ent_r.expiry > ctrl.expiry);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    priority if (ctrl.pop) begin
      ent_nxt = right_ent;
    end else if (ctrl.ins) begin
      priority if (left_gt) begin
        ent_nxt = left_ent;
      end else if (gt || (!ent_r.valid && left_ent.valid)) begin
        ent_nxt.valid  = 1'b1;
        ent_nxt.expiry = ctrl.expiry;
        ent_nxt.id     = ctrl.id;
        ent_nxt.tag    = ctrl.tag;
      end else begin
        ent_nxt = ent_r;
      end
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.expiry <= ent_nxt.expiry;
    ent_r.id     <= ent_nxt.id;
    ent_r.tag    <= ent_nxt.tag;
  end

endmodule

[rtl/core/sorted_timer_expiry_queue_top.sv]
// sorted timer expiry queue: tick counter plus a chain of sorted cells
// an insert causes no transaction unless the queue is full
// a tick enters the pop state, which pops expired entries while the output register is free
// results leave through an output register: a reject in the cycle after its insert, expired
// entries via the pop state after their tick; a stalled result waits there and holds back the next
// reset clears the tick counter and the cell valid bits directly, no clearing pass
module sorted_timer_expiry_queue_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [stq_pkg::TIME_BITS-1:0]  in_expiry_time,
  input  logic [stq_pkg::ID_BITS-1:0]    in_requester_id,
  input  logic [stq_pkg::TAG_BITS-1:0]   in_message_tag,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic [stq_pkg::ID_BITS-1:0]    out_dest_id,
  output logic [stq_pkg::TAG_BITS-1:0]   out_tag_out,
  output logic [stq_pkg::TIME_BITS-1:0]  out_time_out,
  output logic                           out_last
);
  import stq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  logic [TIME_BITS-1:0] tick_r;
  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [ID_BITS-1:0]   out_id_r;
  logic [TAG_BITS-1:0]  out_tag_r;
  logic [TIME_BITS-1:0] out_time_r;
  logic                 out_last_r;

  entry_t     ent [QUEUE_DEPTH];
  logic       gt  [QUEUE_DEPTH];
  cell_ctrl_t ctrl;

  logic accept;
  logic out_free;
  logic full;
  logic head_exp;
  logic next_exp;
  logic tick_acc;
  logic reject;

  entry_t head_bound;
  entry_t tail_bound;

  assign out_free = !out_valid_r || !out_stall;
  assign full     = ent[QUEUE_DEPTH-1].valid;
  assign head_exp = ent[0].valid && (ent[0].expiry <= tick_r);
  assign next_exp = ent[1].valid && (ent[1].expiry <= tick_r);
  assign accept   = in_valid && !in_stall;

  // the head cell sees a valid, never-later neighbor; the tail shifts in nothing
  always_comb begin
    head_bound        = '0;
    head_bound.valid  = 1'b1;
    tail_bound        = '0;
  end

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      entry_t left_ent;
      logic   left_gt;
      entry_t right_ent;
      if (gi == 0) begin : g_head
        assign left_ent = head_bound;
        assign left_gt  = 1'b0;
      end else begin : g_mid
        assign left_ent = ent[gi-1];
        assign left_gt  = gt[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign right_ent = tail_bound;
      end else begin : g_body
        assign right_ent = ent[gi+1];
      end
      stq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .left_ent  (left_ent),
        .left_gt   (left_gt),
        .right_ent (right_ent),
        .ent       (ent[gi]),
        .gt        (gt[gi])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tick_acc) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (!head_exp) begin
          state_nxt = ST_IDLE;
        end else if (out_free && !next_exp) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    // a rejected insert needs the output register, so hold off while it is blocked
    in_stall    = (state_r != ST_IDLE) || (out_valid_r && out_stall && full);
    tick_acc    = accept && !in_action;
    reject      = accept && in_action && full;
    ctrl.ins    = accept && in_action && !full;
    ctrl.pop    = (state_r == ST_POP) && head_exp && out_free;
    ctrl.expiry = in_expiry_time;
    ctrl.id     = in_requester_id;
    ctrl.tag    = in_message_tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (tick_acc) begin
        tick_r <= tick_r + 1'b1;
      end
      if (reject || ctrl.pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (reject) begin
      out_kind_r <= 1'b1;
      out_id_r   <= in_requester_id;
      out_tag_r  <= in_message_tag;
      out_time_r <= in_expiry_time;
      out_last_r <= 1'b1;
    end else if (ctrl.pop) begin
      out_kind_r <= 1'b0;
      out_id_r   <= ent[0].id;
      out_tag_r  <= ent[0].tag;
      out_time_r <= ent[0].expiry;
      out_last_r <= !next_exp;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_dest_id  = out_id_r;
  assign out_tag_out  = out_tag_r;
  assign out_time_out = out_time_r;
  assign out_last     = out_last_r;

endmodule

[dv/sorted_timer_expiry_queue_top_test.sv]
// self-checking testbench for the sorted timer expiry queue
module sorted_timer_expiry_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;

  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_INSERT  = 1'b1;
  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;
  localparam int   LONG_HOLD    = 300;
  localparam int   TAIL_CYCLES  = 40;

  typedef struct packed {
    logic                 sync;
    logic                 action;
    logic [TIME_BITS-1:0] expiry;
    logic [ID_BITS-1:0]   id;
    logic [TAG_BITS-1:0]  tag;
  } request_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] expiry;
    logic [ID_BITS-1:0]   id;
    logic [TAG_BITS-1:0]  tag;
  } timer_entry_t;

  typedef struct packed {
    logic                 kind;
    logic [ID_BITS-1:0]   dest;
    logic [TAG_BITS-1:0]  tag;
    logic [TIME_BITS-1:0] expiry;
    logic                 last;
  } expiry_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_action = ACT_TICK;
  logic [TIME_BITS-1:0] in_expiry_time = '0;
  logic [ID_BITS-1:0]   in_requester_id = '0;
  logic [TAG_BITS-1:0]  in_message_tag = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_kind;
  logic [ID_BITS-1:0]   out_dest_id;
  logic [TAG_BITS-1:0]  out_tag_out;
  logic [TIME_BITS-1:0] out_time_out;
  logic                 out_last;

  sorted_timer_expiry_queue_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_expiry_time  (in_expiry_time),
    .in_requester_id (in_requester_id),
    .in_message_tag  (in_message_tag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_dest_id     (out_dest_id),
    .out_tag_out     (out_tag_out),
    .out_time_out    (out_time_out),
    .out_last        (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // stimulus waiting to go out, and the generator's view of the queue
  request_t             pending_requests[$];
  logic [TIME_BITS-1:0] gen_held[$];
  logic [TIME_BITS-1:0] gen_tick = '0;

  // predicted block state and results still owed
  timer_entry_t         armed_timers[$];
  logic [TIME_BITS-1:0] model_tick = '0;
  expiry_result_t       expected_expiries[$];

  int errors = 0;
  int n_ticks = 0;
  int n_inserts = 0;
  int n_rejected = 0;
  int n_expired = 0;
  int most_popped = 0;

  function automatic void add_insert(logic [TIME_BITS-1:0] expiry, int id, int tag);
    request_t req;
    int pos;
    req.sync   = 1'b0;
    req.action = ACT_INSERT;
    req.expiry = expiry;
    req.id     = id[ID_BITS-1:0];
    req.tag    = tag[TAG_BITS-1:0];
    pending_requests.push_back(req);
    if (gen_held.size() < QUEUE_DEPTH) begin
      pos = gen_held.size();
      while (pos > 0 && gen_held[pos-1] > expiry) pos--;
      gen_held.insert(pos, expiry);
    end
  endfunction

  function automatic void add_tick();
    request_t req;
    req = '0;
    req.action = ACT_TICK;
    pending_requests.push_back(req);
    gen_tick = gen_tick + 1;
    while (gen_held.size() != 0 && gen_held[0] <= gen_tick) void'(gen_held.pop_front());
  endfunction

  function automatic void add_sync();
    request_t req;
    req = '0;
    req.sync = 1'b1;
    pending_requests.push_back(req);
  endfunction

  function automatic void predict_expiries(request_t req);
    timer_entry_t   ent;
    expiry_result_t res;
    int pos;
    int popped;
    if (req.action == ACT_INSERT) begin
      n_inserts++;
      if (armed_timers.size() >= QUEUE_DEPTH) begin
        res.kind   = KIND_REJECT;
        res.dest   = req.id;
        res.tag    = req.tag;
        res.expiry = req.expiry;
        res.last   = 1'b1;
        expected_expiries.push_back(res);
        n_rejected++;
      end else begin
        ent.expiry = req.expiry;
        ent.id     = req.id;
        ent.tag    = req.tag;
        // equal times go behind the ones already waiting
        pos = armed_timers.size();
        while (pos > 0 && armed_timers[pos-1].expiry > req.expiry) pos--;
        armed_timers.insert(pos, ent);
      end
    end else begin
      n_ticks++;
      model_tick = model_tick + 1;
      popped = 0;
      while (popped < armed_timers.size() && armed_timers[popped].expiry <= model_tick)
        popped++;
      for (int i = 0; i < popped; i++) begin
        ent = armed_timers.pop_front();
        res.kind   = KIND_EXPIRED;
        res.dest   = ent.id;
        res.tag    = ent.tag;
        res.expiry = ent.expiry;
        res.last   = (i == popped - 1);
        expected_expiries.push_back(res);
      end
      n_expired += popped;
      if (popped > most_popped) most_popped = popped;
    end
  endfunction

  function automatic void check_field(string name, logic [TIME_BITS-1:0] want,
                                      logic [TIME_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // driver: bursts of items with random gaps, sync markers wait for the block to drain
  request_t on_wire = '0;
  int       burst_left = 8;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_expiries(on_wire);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0 && pending_requests[0].sync) begin
          in_valid <= 1'b0;
          if (expected_expiries.size() == 0) void'(pending_requests.pop_front());
        end else if (pending_requests.size() != 0) begin
          on_wire = pending_requests.pop_front();
          in_valid        <= 1'b1;
          in_action       <= on_wire.action;
          in_expiry_time  <= on_wire.expiry;
          in_requester_id <= on_wire.id;
          in_message_tag  <= on_wire.tag;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall mode redrawn whenever the low bits of its cycle counter wrap, one long hold on the first bounce
  int   hold_left = 0;
  logic hold_used = 1'b0;
  logic [1:0] rx_mode = '0;
  logic [7:0] rx_cycle = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_used <= 1'b0;
      rx_mode   <= '0;
      rx_cycle  <= '0;
    end else begin
      rx_cycle <= rx_cycle + 8'd1;
      if (rx_cycle[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_used && out_valid && out_kind == KIND_REJECT) begin
        hold_left <= LONG_HOLD;
        hold_used <= 1'b1;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          2'd0: out_stall <= 1'b0;
          2'd1: out_stall <= ($urandom_range(0, 3) == 0);
          2'd2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= rx_cycle[1];
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    expiry_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_expiries.size() == 0) begin
        $display("%0t ns: unexpected transaction, expected none, actual kind %0d id %0h",
                 $time, out_kind, out_dest_id);
        $display("  tag %0h time %0h last %0d", out_tag_out, out_time_out, out_last);
        errors++;
      end else begin
        want = expected_expiries.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("dest_id", want.dest, out_dest_id);
        check_field("tag_out", want.tag, out_tag_out);
        check_field("time_out", want.expiry, out_time_out);
        check_field("last", want.last, out_last);
      end
    end
  end

  initial begin
    int r;
    int unsigned back;
    // directed: extremes of id and tag, expiry already due, equal times, late insert
    // that sorts ahead, and a tick with nothing due
    add_insert(0, 0, 0);
    add_insert(1, 15, 255);
    add_insert(3, 5, 8'h11);
    add_insert(3, 6, 8'h22);
    add_insert(2, 10, 8'haa);
    repeat (4) add_tick();
    add_sync();
    // sixteen entries with one time, bounced requests, then two ticks, the second of which pops them all
    back = gen_tick + 2;
    repeat (QUEUE_DEPTH) add_insert(back, $urandom_range(0, 15), $urandom_range(0, 255));
    repeat (3) add_insert($urandom, $urandom_range(0, 15), $urandom_range(0, 255));
    repeat (2) add_tick();
    add_sync();
    repeat (2) begin
      for (int k = 0; k < 35; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          add_tick();
        end else if (gen_held.size() >= QUEUE_DEPTH) begin
          add_insert($urandom, $urandom_range(0, 15), $urandom_range(0, 255));
        end else if (r < 52) begin
          back = $urandom_range(0, 3);
          if (back > gen_tick) back = gen_tick;
          add_insert(gen_tick - back, $urandom_range(0, 15), $urandom_range(0, 255));
        end else begin
          add_insert(gen_tick + $urandom_range(0, 8), $urandom_range(0, 15),
                     $urandom_range(0, 255));
        end
      end
      // fill to the brim, then requests that bounce
      while (gen_held.size() < QUEUE_DEPTH)
        add_insert(gen_tick + $urandom_range(1, 5), $urandom_range(0, 15),
                   $urandom_range(0, 255));
      repeat (3) add_insert($urandom, $urandom_range(0, 15), $urandom_range(0, 255));
      repeat (6) add_tick();
      add_sync();
    end
    // far-off entries that sort behind a near one and stay put
    add_insert(32'hffff_ffff, 15, 255);
    add_insert(32'h8000_0000, 0, 0);
    add_insert(gen_tick + 1, 3, 8'h5a);
    repeat (2) add_tick();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_expiries.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d ticks and %0d inserts sent, %0d entries expired, %0d inserts rejected",
             n_ticks, n_inserts, n_expired, n_rejected);
    $display("largest pop on one tick: %0d entries, %0d mismatches", most_popped, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("%0t ns: timeout, %0d results still owed", $time, expected_expiries.size());
    $display("simulation failed");
    $finish;
  end

endmodule

[sorted_timer_expiry_queue_top.f]
rtl/core/stq_pkg.sv
rtl/core/stq_cell.sv
rtl/core/sorted_timer_expiry_queue_top.sv
dv/sorted_timer_expiry_queue_top_test.sv
